FILE: hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// uer_pkg
// Types and constants shared by the ultrasonic echo ranger modules.
// ----------------------------------------------------------------------------
package uer_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TRIGGER_TICKS    = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd1;
    localparam logic [1:0] CFG_OVER_RANGE_COUNT = 2'd2;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam logic [7:0]  TRIGGER_TICKS_RST    = 8'd14;
    localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd50667;
    localparam logic [15:0] OVER_RANGE_COUNT_RST = 16'd28000;

    localparam logic [7:0]  TRIG_CNT_MAX = 8'hFF;
    localparam logic [15:0] CNT_MAX      = 16'hFFFF;

    // result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TIMEOUT    = 2'd1;
    localparam logic [1:0] ST_OVER_RANGE = 2'd2;

    // count*30/232 == (count*MM_MULT) >> MM_SHIFT, exact for any 16-bit count
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned MM_MULT_W = 20;
    localparam logic [MM_MULT_W-1:0] MM_MULT = 20'd542367;
    localparam int unsigned MM_SHIFT = 22;
    localparam int unsigned DIST_W   = 14;
    localparam int unsigned PROD_W   = COUNT_W + MM_MULT_W;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] over_range_count;
    } t_cfg;

    typedef struct packed {
        logic req_type;
        logic echo_level;
    } t_in_word;

    typedef struct packed {
        logic        trig_out;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [13:0] distance_mm;
    } t_out_word;

endpackage

FILE: hw/rtl/uer_cfg.sv
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration register file: pulse length, echo timeout, over-range limit.
// ----------------------------------------------------------------------------
module uer_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output uer_pkg::t_cfg                   o_cfg
);

    uer_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks    <= uer_pkg::TRIGGER_TICKS_RST;
            r_cfg.timeout_ticks    <= uer_pkg::TIMEOUT_TICKS_RST;
            r_cfg.over_range_count <= uer_pkg::OVER_RANGE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                uer_pkg::CFG_TRIGGER_TICKS: begin
                    r_cfg.trigger_ticks <= i_cfg_wdata[7:0];
                end
                uer_pkg::CFG_TIMEOUT_TICKS: begin
                    r_cfg.timeout_ticks <= i_cfg_wdata;
                end
                uer_pkg::CFG_OVER_RANGE_COUNT: begin
                    r_cfg.over_range_count <= i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hw/rtl/uer_mm_conv.sv
// ----------------------------------------------------------------------------
// uer_mm_conv
// Echo count to millimetres: count*30/232 by reciprocal multiply and shift.
// ----------------------------------------------------------------------------
module uer_mm_conv (
    input  logic [uer_pkg::COUNT_W-1:0] i_count,
    output logic [uer_pkg::DIST_W-1:0]  o_distance_mm
);

    logic [uer_pkg::PROD_W-1:0] prod;

    assign prod = {{uer_pkg::MM_MULT_W{1'b0}}, i_count}
                * {{uer_pkg::COUNT_W{1'b0}}, uer_pkg::MM_MULT};

    assign o_distance_mm = prod[uer_pkg::MM_SHIFT +: uer_pkg::DIST_W];

endmodule

FILE: hw/rtl/uer_ctrl.sv
// ----------------------------------------------------------------------------
// uer_ctrl
// Measurement sequencer: trigger pulse, echo counting, timeout and result.
// ----------------------------------------------------------------------------
module uer_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  uer_pkg::t_in_word   i_word,
    input  uer_pkg::t_cfg       i_cfg,
    output uer_pkg::t_out_word  o_word
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2
    } t_phase;

    t_phase      r_phase,         n_phase;
    logic [7:0]  r_trigger_count, n_trigger_count;
    logic [15:0] r_wait_count,    n_wait_count;
    logic [15:0] r_echo_count,    n_echo_count;
    logic        r_echo_prev;

    logic                        finish;
    logic                        expired;
    logic [uer_pkg::DIST_W-1:0]  mm_dist;

    always_comb begin
        n_phase         = r_phase;
        n_trigger_count = r_trigger_count;
        n_wait_count    = r_wait_count;
        n_echo_count    = r_echo_count;
        finish          = 1'b0;
        expired         = 1'b0;

        if (i_word.req_type) begin
            n_phase         = PH_TRIG;
            n_trigger_count = 8'd1;
            n_wait_count    = '0;
            n_echo_count    = '0;
        end else begin
            case (r_phase)
                PH_TRIG: begin
                    if (r_trigger_count != uer_pkg::TRIG_CNT_MAX) begin
                        n_trigger_count = r_trigger_count + 8'd1;
                    end
                end
                PH_WAIT: begin
                    // falling edge ends the echo without counting this tick
                    if (r_echo_prev && !i_word.echo_level) begin
                        finish = 1'b1;
                    end else begin
                        if (i_word.echo_level && r_echo_count != uer_pkg::CNT_MAX) begin
                            n_echo_count = r_echo_count + 16'd1;
                        end
                        if (r_wait_count != uer_pkg::CNT_MAX) begin
                            n_wait_count = r_wait_count + 16'd1;
                        end
                        if (n_wait_count >= i_cfg.timeout_ticks) begin
                            finish  = 1'b1;
                            expired = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        if (n_phase == PH_TRIG && n_trigger_count >= i_cfg.trigger_ticks) begin
            n_phase = PH_WAIT;
        end
        if (finish) begin
            n_phase = PH_IDLE;
        end
    end

    uer_mm_conv u_mm_conv (
        .i_count       (n_echo_count),
        .o_distance_mm (mm_dist)
    );

    always_comb begin
        o_word.trig_out    = (n_phase != PH_TRIG);
        o_word.busy_res    = (n_phase == PH_TRIG) || (n_phase == PH_WAIT);
        o_word.done_res    = finish;
        o_word.status      = uer_pkg::ST_OK;
        o_word.distance_mm = '0;
        if (finish) begin
            if (expired && n_echo_count == '0) begin
                o_word.status = uer_pkg::ST_TIMEOUT;
            end else if (n_echo_count >= i_cfg.over_range_count) begin
                o_word.status = uer_pkg::ST_OVER_RANGE;
            end else begin
                o_word.distance_mm = mm_dist;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_trigger_count <= '0;
            r_wait_count    <= '0;
            r_echo_count    <= '0;
            r_echo_prev     <= 1'b0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_trigger_count <= n_trigger_count;
            r_wait_count    <= n_wait_count;
            r_echo_count    <= n_echo_count;
            r_echo_prev     <= i_word.echo_level;
        end
    end

endmodule

FILE: hw/rtl/uer_out_reg.sv
// ----------------------------------------------------------------------------
// uer_out_reg
// Result register with valid/stall handshake; one word of buffering.
// ----------------------------------------------------------------------------
module uer_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  uer_pkg::t_out_word  i_word,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_in_stall,
    output uer_pkg::t_out_word  o_out_data
);

    logic               r_valid;
    uer_pkg::t_out_word r_word;

    // hold the input back only while a word sits here and cannot leave
    assign o_in_stall = r_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_word;

endmodule

FILE: hw/rtl/ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Tick-driven ultrasonic range measurement controller.
// ----------------------------------------------------------------------------
// Each input word, one timer tick or a start request, yields exactly one
// result word in the cycle after it is accepted. A new word is taken in
// every cycle unless the result register is full and stalled; the state
// update (sequencer plus one 16x20 multiply for the millimetre conversion)
// feeds the result register. The user writes configuration through the plain
// write port while no measurement is running; the block does not enforce it.
module ultrasonic_echo_ranger (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  uer_pkg::t_in_word               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output uer_pkg::t_out_word              o_out_data
);

    uer_pkg::t_cfg      cfg;
    uer_pkg::t_out_word next_word;
    logic               accept;

    assign accept = i_in_valid && !o_in_stall;

    uer_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    uer_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_data),
        .i_cfg    (cfg),
        .o_word   (next_word)
    );

    uer_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_word      (next_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_in_stall  (o_in_stall),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/uer_checker.sv
// ----------------------------------------------------------------------------
// uer_checker
// Port-level checks on the ranger's result words and handshake.
// ----------------------------------------------------------------------------
module uer_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  uer_pkg::t_out_word  o_out_data
);

    // a completing word always leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> !o_out_data.busy_res)
        else $error("done word shows busy");

    // status and distance only carry news on a completing word
    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.done_res
            |-> o_out_data.status == uer_pkg::ST_OK && o_out_data.distance_mm == '0)
        else $error("status or distance set without done");

    // failed measurements report no range, and no unknown status code
    a_fail_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != uer_pkg::ST_OK
            |-> o_out_data.distance_mm == '0
                && (o_out_data.status == uer_pkg::ST_TIMEOUT
                    || o_out_data.status == uer_pkg::ST_OVER_RANGE))
        else $error("bad status or distance on failure");

    // trigger pulse only inside a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.trig_out |-> o_out_data.busy_res)
        else $error("trigger low while idle");

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the ultrasonic echo ranger.
// Tick and start words go in through the input channel with random gaps.
// A predictor of the measurement sequencer works out each result word as
// the input word is taken. The output channel is checked word by word under
// random back-pressure. The run covers several register settings, including
// the lowest, the highest and zero, and one long measurement sent back to back.
// ---------------------------------------------------------------------------
module tb;

    typedef enum logic [1:0] {RNG_IDLE, RNG_TRIG, RNG_WAIT} t_rng_phase;

    localparam int unsigned TICK_MM_NUM = 30;
    localparam int unsigned TICK_MM_DEN = 232;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned LONG_HOLD   = 60;

    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [uer_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    uer_pkg::t_in_word              in_word   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    uer_pkg::t_out_word             out_word;

    ultrasonic_echo_ranger u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the registers and the sequencer state
    logic [7:0]  cfg_trigger    = uer_pkg::TRIGGER_TICKS_RST;
    logic [15:0] cfg_timeout    = uer_pkg::TIMEOUT_TICKS_RST;
    logic [15:0] cfg_over_range = uer_pkg::OVER_RANGE_COUNT_RST;
    t_rng_phase  rng_phase      = RNG_IDLE;
    logic [7:0]  trig_cnt       = '0;
    logic [15:0] wait_cnt       = '0;
    logic [15:0] echo_cnt       = '0;
    logic        echo_prev      = 1'b0;

    uer_pkg::t_in_word  pending_words[$];
    uer_pkg::t_out_word expected_results[$];

    logic        no_idle       = 1'b0;
    int unsigned words_queued  = 0;
    int unsigned words_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    int unsigned setting_count = 0;
    int unsigned n_ok          = 0;
    int unsigned n_timeout     = 0;
    int unsigned n_over        = 0;

    function automatic uer_pkg::t_out_word next_range_result(uer_pkg::t_in_word w);
        uer_pkg::t_out_word r;
        logic               finish;
        logic               expired;
        int unsigned        mm;
        r       = '0;
        finish  = 1'b0;
        expired = 1'b0;
        if (w.req_type) begin
            rng_phase = RNG_TRIG;
            trig_cnt  = 8'd1;
            wait_cnt  = '0;
            echo_cnt  = '0;
        end else if (rng_phase == RNG_TRIG) begin
            if (trig_cnt != uer_pkg::TRIG_CNT_MAX) begin
                trig_cnt = trig_cnt + 8'd1;
            end
        end else if (rng_phase == RNG_WAIT) begin
            // falling edge ends the measurement before anything is counted
            if (echo_prev && !w.echo_level) begin
                finish = 1'b1;
            end else begin
                if (w.echo_level && echo_cnt != uer_pkg::CNT_MAX) begin
                    echo_cnt = echo_cnt + 16'd1;
                end
                if (wait_cnt != uer_pkg::CNT_MAX) begin
                    wait_cnt = wait_cnt + 16'd1;
                end
                if (wait_cnt >= cfg_timeout) begin
                    finish  = 1'b1;
                    expired = 1'b1;
                end
            end
        end
        if (rng_phase == RNG_TRIG && trig_cnt >= cfg_trigger) begin
            rng_phase = RNG_WAIT;
        end
        if (finish) begin
            rng_phase  = RNG_IDLE;
            r.done_res = 1'b1;
            if (expired && echo_cnt == 16'd0) begin
                r.status = uer_pkg::ST_TIMEOUT;
            end else if (echo_cnt >= cfg_over_range) begin
                r.status = uer_pkg::ST_OVER_RANGE;
            end else begin
                r.status      = uer_pkg::ST_OK;
                mm            = (int'(echo_cnt) * TICK_MM_NUM) / TICK_MM_DEN;
                r.distance_mm = mm[13:0];
            end
        end
        echo_prev  = w.echo_level;
        r.trig_out = (rng_phase != RNG_TRIG);
        r.busy_res = (rng_phase != RNG_IDLE);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("word %0d: %s expected %0d got %0d", results_seen, name, want, got);
            end
        end
    endfunction

    // driver: one word offered at a time, random gap before the next
    int unsigned send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(next_range_result(in_word));
                words_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 4);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result word and draws its own stall
    int unsigned hold_left = 0;

    always @(posedge i_clk) begin : monitor
        uer_pkg::t_out_word want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("word %0d: result with nothing expected", results_seen);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("trig_out", 32'(want.trig_out), 32'(out_word.trig_out));
                    check_field("busy_res", 32'(want.busy_res), 32'(out_word.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(out_word.done_res));
                    check_field("status", 32'(want.status), 32'(out_word.status));
                    check_field("distance_mm", 32'(want.distance_mm),
                                32'(out_word.distance_mm));
                    if (want.done_res) begin
                        case (want.status)
                            uer_pkg::ST_OK:         n_ok++;
                            uer_pkg::ST_TIMEOUT:    n_timeout++;
                            uer_pkg::ST_OVER_RANGE: n_over++;
                            default: ;
                        endcase
                    end
                end
                results_seen++;
                hold_left = no_idle ? 0 : $urandom_range(0, 4);
                // long hold so the result register fills and the input stalls
                if (results_seen == 80 || results_seen == 450) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic queue_word(logic start, logic echo);
        uer_pkg::t_in_word w;
        w.req_type   = start;
        w.echo_level = echo;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [uer_pkg::CFG_ADDR_W-1:0] idx,
                             logic [uer_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            uer_pkg::CFG_TRIGGER_TICKS:    cfg_trigger    = val[7:0];
            uer_pkg::CFG_TIMEOUT_TICKS:    cfg_timeout    = val;
            uer_pkg::CFG_OVER_RANGE_COUNT: cfg_over_range = val;
            default: ;
        endcase
    endtask

    // drain, run any open measurement to its end, then load new registers
    task automatic apply_setting(logic [7:0] trig, logic [15:0] tmo, logic [15:0] over);
        wait_drained();
        while (rng_phase != RNG_IDLE) begin
            queue_word(1'b0, 1'b1);
            queue_word(1'b0, 1'b0);
            wait_drained();
        end
        write_reg(uer_pkg::CFG_TRIGGER_TICKS, {8'd0, trig});
        write_reg(uer_pkg::CFG_TIMEOUT_TICKS, tmo);
        write_reg(uer_pkg::CFG_OVER_RANGE_COUNT, over);
        setting_count++;
    endtask

    task automatic queue_measurement();
        int unsigned style;
        int unsigned n_trig;
        int unsigned n_high;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            // noise: loose words, starts rarer than ticks
            repeat ($urandom_range(1, 8)) begin
                queue_word($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
            end
        end else begin
            n_trig = (cfg_trigger > 8'd1) ? int'(cfg_trigger) - 1 : 0;
            queue_word(1'b1, 1'($urandom_range(0, 1)));
            if (style == 1) begin
                // restart while busy
                repeat ($urandom_range(0, n_trig + 3)) begin
                    queue_word(1'b0, 1'($urandom_range(0, 1)));
                end
                queue_word(1'b1, 1'($urandom_range(0, 1)));
            end
            repeat (n_trig + $urandom_range(0, 1)) begin
                queue_word(1'b0, 1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 3)) queue_word(1'b0, 1'b0);
            n_high = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300)
                                                 : $urandom_range(0, 40);
            repeat (n_high) queue_word(1'b0, 1'b1);
            queue_word(1'b0, 1'b0);
            repeat ($urandom_range(0, 2)) queue_word(1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random(int unsigned count);
        int unsigned goal;
        goal = words_queued + count;
        while (words_queued < goal) begin
            queue_measurement();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the registers
        run_random(80);

        // short pulse, short timeout, low over-range threshold
        apply_setting(8'd2, 16'd4, 16'd3);
        queue_word(1'b0, 1'b0);
        queue_word(1'b0, 1'b1);
        // falling edge on the first armed tick left over from the pulse
        queue_word(1'b1, 1'b1);
        queue_word(1'b0, 1'b1);
        queue_word(1'b0, 1'b0);
        // no echo at all: timeout
        queue_word(1'b1, 1'b0);
        repeat (5) queue_word(1'b0, 1'b0);
        // echo still high at expiry: judged by the count
        queue_word(1'b1, 1'b0);
        repeat (5) queue_word(1'b0, 1'b1);
        // start while busy, then a short echo
        queue_word(1'b1, 1'b0);
        queue_word(1'b1, 1'b0);
        queue_word(1'b0, 1'b0);
        repeat (2) queue_word(1'b0, 1'b1);
        queue_word(1'b0, 1'b0);
        run_random(40);

        apply_setting(8'd1, 16'd1, 16'd1);
        run_random(40);

        apply_setting(8'd0, 16'd0, 16'd0);
        run_random(40);

        apply_setting(8'd255, 16'hFFFF, 16'hFFFF);

        // longest pulse and a long echo without idling on either side
        wait_drained();
        no_idle = 1'b1;
        queue_word(1'b1, 1'b0);
        repeat (254) queue_word(1'b0, 1'b0);
        repeat (60) queue_word(1'b0, 1'b1);
        queue_word(1'b0, 1'b0);
        wait_drained();
        no_idle = 1'b0;

        repeat (3) begin
            apply_setting(8'($urandom_range(1, 20)), 16'($urandom_range(1, 200)),
                          16'($urandom_range(1, 300)));
            run_random(40);
        end

        wait_drained();
        $display("%0d words through %0d register settings", words_sent, setting_count + 1);
        $display("measurements: %0d in range, %0d timed out, %0d over range",
                 n_ok, n_timeout, n_over);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures, %0d results outstanding", fail_count,
                     expected_results.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("run did not finish in time: %0d words sent, %0d results seen",
                 words_sent, results_seen);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/uer_pkg.sv
hw/rtl/uer_cfg.sv
hw/rtl/uer_mm_conv.sv
hw/rtl/uer_ctrl.sv
hw/rtl/uer_out_reg.sv
hw/rtl/ultrasonic_echo_ranger.sv
hw/rtl/uer_checker.sv
tb/tb.sv
